// ===== design/hpe_pkg.sv =====
// Shared types, constants and width helpers for the head pose eye transform.
package hpe_pkg;

    // Field widths of the channels and registers.
    localparam int QUAT_W    = 16;
    localparam int POS_W     = 32;
    localparam int EYE_W     = 24;
    localparam int IPD_W     = 16;
    localparam int LOOK_W    = 16;
    localparam int GAZE_W    = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Default number of fraction bits of the quaternion and look vector.
    localparam int QUAT_FRAC_BITS_DEF = 14;

    // Rotated vectors: eye offsets carry one extra fraction bit for the half IPD.
    localparam int VEC_W = EYE_W + 2;

    // Rounded rotation result before the neck add.
    localparam int RND_W = VEC_W + 12;

    // Register stages inside the rotation unit.
    localparam int ROT_LAT = 4;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EYE_CENTER_X = 3'd0,
        REG_EYE_CENTER_Y = 3'd1,
        REG_EYE_CENTER_Z = 3'd2,
        REG_IPD          = 3'd3,
        REG_LOOK_X       = 3'd4,
        REG_LOOK_Y       = 3'd5,
        REG_LOOK_Z       = 3'd6
    } reg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [EYE_W-1:0]  EYE_CENTER_X_RST = 24'd0;
    localparam logic [EYE_W-1:0]  EYE_CENTER_Y_RST = 24'd6554;
    localparam logic [EYE_W-1:0]  EYE_CENTER_Z_RST = 24'(-10486);
    localparam logic [IPD_W-1:0]  IPD_RST          = 16'd4194;
    localparam logic [LOOK_W-1:0] LOOK_X_RST       = 16'd0;
    localparam logic [LOOK_W-1:0] LOOK_Y_RST       = 16'd0;
    localparam logic [LOOK_W-1:0] LOOK_Z_RST       = 16'(-16384);

    // One input beat.
    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [POS_W-1:0]  neck_x;
        logic signed [POS_W-1:0]  neck_y;
        logic signed [POS_W-1:0]  neck_z;
    } pose_t;

    // One result beat.
    typedef struct packed {
        logic signed [POS_W-1:0]  left_eye_x;
        logic signed [POS_W-1:0]  left_eye_y;
        logic signed [POS_W-1:0]  left_eye_z;
        logic signed [POS_W-1:0]  right_eye_x;
        logic signed [POS_W-1:0]  right_eye_y;
        logic signed [POS_W-1:0]  right_eye_z;
        logic signed [GAZE_W-1:0] gaze_x;
        logic signed [GAZE_W-1:0] gaze_y;
        logic signed [GAZE_W-1:0] gaze_z;
    } result_t;

    // Width of the square root of (sum of squares << 2F).
    function automatic int root_w(int f);
        return f + 17;
    endfunction

    // Quotient bits of one normalized component magnitude.
    function automatic int quo_w(int f);
        return f + 3;
    endfunction

    // Signed width of one normalized component.
    function automatic int nrm_w(int f);
        return f + 4;
    endfunction

    // Exact width of one rotation result.
    function automatic int rot_w(int f);
        return 2 * nrm_w(f) + VEC_W + 4;
    endfunction

    // Stages of the normalizer: squares, sum, root digits, quotient bits, sign.
    function automatic int norm_lat(int f);
        return 3 + root_w(f) + quo_w(f);
    endfunction

    // Accept edge to result strobe.
    function automatic int total_lat(int f);
        return norm_lat(f) + ROT_LAT + 2;
    endfunction

endpackage

// ===== design/head_pose_eye_transform_unit.sv =====
// Top level of the head pose eye transform: registers, normalizer, rotations, output.
//
// Channels: an input beat (pose) is taken at each rising edge with start high
// and busy low; busy stays low, so a new pose may enter every cycle. Each
// result beat appears on result for exactly one cycle with done high.
// Configuration is a plain write port (wr_en, wr_index, wr_data) with no wait
// state; writes beyond the last register are ignored. Write only while no
// pose is in flight.
// Stages from accept to done: the root stages (QUAT_FRAC_BITS + 17, one bit
// each), the division stages (QUAT_FRAC_BITS + 3, one quotient bit each), two
// front stages, one sign stage, four rotation stages and two rounding and
// saturation stages.
// Throughput: one pose per cycle, fully pipelined.
// Reset: clears all valid bits and loads the default head model into the
// registers. The receiver cannot stall; results are never held back.
module head_pose_eye_transform_unit #(
    parameter int QUAT_FRAC_BITS = hpe_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  hpe_pkg::pose_t                 pose,
    output logic                           done,
    output hpe_pkg::result_t               result,
    input  logic                           wr_en,
    input  logic [hpe_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [hpe_pkg::CFG_W-1:0]      wr_data
);
    import hpe_pkg::*;

    localparam int F      = QUAT_FRAC_BITS;
    localparam int NW     = nrm_w(F);
    localparam int OW     = rot_w(F);
    localparam int S_EYE  = 2 * F + 1;
    localparam int S_LOOK = 2 * F;
    localparam int DLY    = norm_lat(F) + ROT_LAT + 1;
    localparam int SUM_W  = RND_W + 1;

    // Configuration registers.
    logic [EYE_W-1:0]  eye_x_reg, eye_y_reg, eye_z_reg;
    logic [IPD_W-1:0]  ipd_reg;
    logic [LOOK_W-1:0] look_x_reg, look_y_reg, look_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg  <= EYE_CENTER_X_RST;
            eye_y_reg  <= EYE_CENTER_Y_RST;
            eye_z_reg  <= EYE_CENTER_Z_RST;
            ipd_reg    <= IPD_RST;
            look_x_reg <= LOOK_X_RST;
            look_y_reg <= LOOK_Y_RST;
            look_z_reg <= LOOK_Z_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_EYE_CENTER_X: eye_x_reg  <= wr_data[EYE_W-1:0];
                REG_EYE_CENTER_Y: eye_y_reg  <= wr_data[EYE_W-1:0];
                REG_EYE_CENTER_Z: eye_z_reg  <= wr_data[EYE_W-1:0];
                REG_IPD:          ipd_reg    <= wr_data[IPD_W-1:0];
                REG_LOOK_X:       look_x_reg <= wr_data[LOOK_W-1:0];
                REG_LOOK_Y:       look_y_reg <= wr_data[LOOK_W-1:0];
                REG_LOOK_Z:       look_z_reg <= wr_data[LOOK_W-1:0];
                default:          ;
            endcase
        end
    end

    // Eye offsets at one extra fraction bit, and the look vector.
    logic [2:0][VEC_W-1:0] vl, vr, vk;
    logic signed [VEC_W-1:0] ve_x, ipd_ext;

    always_comb
    begin
        ve_x    = VEC_W'($signed({eye_x_reg, 1'b0}));
        ipd_ext = VEC_W'(ipd_reg);
        vl[0]   = ve_x - ipd_ext;
        vr[0]   = ve_x + ipd_ext;
        vl[1]   = VEC_W'($signed({eye_y_reg, 1'b0}));
        vr[1]   = vl[1];
        vl[2]   = VEC_W'($signed({eye_z_reg, 1'b0}));
        vr[2]   = vl[2];
        vk[0]   = VEC_W'($signed(look_x_reg));
        vk[1]   = VEC_W'($signed(look_y_reg));
        vk[2]   = VEC_W'($signed(look_z_reg));
    end

    // Normalizer.
    logic               nv;
    logic [3:0][NW-1:0] n;

    hpe_norm #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .q         ({pose.quat_z, pose.quat_y, pose.quat_x, pose.quat_w}),
        .out_valid (nv),
        .n         (n)
    );

    // Three rotations share the normalized quaternion.
    logic               rv_l, rv_r, rv_k;
    logic [2:0][OW-1:0] rl, rr, rk;

    hpe_rot #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_rot_left (
        .clk(clk), .rst_n(rst_n), .in_valid(nv), .n(n), .v(vl),
        .out_valid(rv_l), .r(rl)
    );

    hpe_rot #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_rot_right (
        .clk(clk), .rst_n(rst_n), .in_valid(nv), .n(n), .v(vr),
        .out_valid(rv_r), .r(rr)
    );

    hpe_rot #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_rot_look (
        .clk(clk), .rst_n(rst_n), .in_valid(nv), .n(n), .v(vk),
        .out_valid(rv_k), .r(rk)
    );

    // Neck position travels alongside the pipeline.
    logic [2:0][POS_W-1:0] neck_dly_reg [DLY];

    always_ff @(posedge clk)
    begin
        neck_dly_reg[0] <= {pose.neck_z, pose.neck_y, pose.neck_x};
        for (int k = 1; k < DLY; k++)
        begin
            neck_dly_reg[k] <= neck_dly_reg[k-1];
        end
    end

    // Round to nearest, halves up.
    logic                   rnd_v_reg;
    logic signed [RND_W-1:0] rnd_l_reg [3], rnd_r_reg [3], rnd_k_reg [3];
    logic signed [RND_W-1:0] rnd_l_next [3], rnd_r_next [3], rnd_k_next [3];

    always_comb
    begin
        logic signed [OW-1:0] hl, hr, hk;
        for (int i = 0; i < 3; i++)
        begin
            hl            = $signed(rl[i]) + (OW'(1) <<< (S_EYE - 1));
            hr            = $signed(rr[i]) + (OW'(1) <<< (S_EYE - 1));
            hk            = $signed(rk[i]) + (OW'(1) <<< (S_LOOK - 1));
            rnd_l_next[i] = RND_W'(hl >>> S_EYE);
            rnd_r_next[i] = RND_W'(hr >>> S_EYE);
            rnd_k_next[i] = RND_W'(hk >>> S_LOOK);
        end
    end

    // Neck add and saturation.
    logic [2:0][POS_W-1:0]  eye_l, eye_r;
    logic [2:0][GAZE_W-1:0] gz;

    always_comb
    begin
        logic signed [SUM_W-1:0] sl, sr, nk;
        for (int i = 0; i < 3; i++)
        begin
            nk = SUM_W'($signed(neck_dly_reg[DLY-1][i]));
            sl = SUM_W'(rnd_l_reg[i]) + nk;
            sr = SUM_W'(rnd_r_reg[i]) + nk;
            if (sl[SUM_W-1:POS_W-1] != '0 && sl[SUM_W-1:POS_W-1] != '1)
            begin
                eye_l[i] = sl[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
            end
            else
            begin
                eye_l[i] = sl[POS_W-1:0];
            end
            if (sr[SUM_W-1:POS_W-1] != '0 && sr[SUM_W-1:POS_W-1] != '1)
            begin
                eye_r[i] = sr[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
            end
            else
            begin
                eye_r[i] = sr[POS_W-1:0];
            end
            if (rnd_k_reg[i][RND_W-1:GAZE_W-1] != '0 && rnd_k_reg[i][RND_W-1:GAZE_W-1] != '1)
            begin
                gz[i] = rnd_k_reg[i][RND_W-1] ? {1'b1, {(GAZE_W-1){1'b0}}}
                                              : {1'b0, {(GAZE_W-1){1'b1}}};
            end
            else
            begin
                gz[i] = rnd_k_reg[i][GAZE_W-1:0];
            end
        end
    end

    logic    done_reg;
    result_t result_reg, result_next;

    always_comb
    begin
        result_next.left_eye_x  = eye_l[0];
        result_next.left_eye_y  = eye_l[1];
        result_next.left_eye_z  = eye_l[2];
        result_next.right_eye_x = eye_r[0];
        result_next.right_eye_y = eye_r[1];
        result_next.right_eye_z = eye_r[2];
        result_next.gaze_x      = gz[0];
        result_next.gaze_y      = gz[1];
        result_next.gaze_z      = gz[2];
    end

    // Output valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            rnd_v_reg <= rv_l && rv_r && rv_k;
            done_reg  <= rnd_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_l_reg  <= rnd_l_next;
        rnd_r_reg  <= rnd_r_next;
        rnd_k_reg  <= rnd_k_next;
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== design/hpe_norm.sv =====
// Pipelined quaternion normalizer: sum of squares, digit-serial root, long division.
module hpe_norm #(
    parameter int QUAT_FRAC_BITS = hpe_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                in_valid,
    input  logic [3:0][hpe_pkg::QUAT_W-1:0]                     q,
    output logic                                                out_valid,
    output logic [3:0][hpe_pkg::nrm_w(QUAT_FRAC_BITS)-1:0]      n
);
    import hpe_pkg::*;

    localparam int F     = QUAT_FRAC_BITS;
    localparam int RW    = root_w(F);
    localparam int QTW   = quo_w(F);
    localparam int NW    = nrm_w(F);
    localparam int SQ_W  = 2 * QUAT_W - 1;
    localparam int SUM_W = SQ_W + 2;
    localparam int MAG_W = QUAT_W;

    // Stage 1: squares and magnitudes.
    logic                       v1_reg;
    logic [3:0][SQ_W-1:0]       sq_reg, sq_next;
    logic [3:0][MAG_W-1:0]      mag1_reg, mag1_next;
    logic [3:0]                 neg1_reg;

    always_comb
    begin
        logic signed [2*QUAT_W-1:0] prod;
        for (int i = 0; i < 4; i++)
        begin
            prod         = $signed(q[i]) * $signed(q[i]);
            sq_next[i]   = prod[SQ_W-1:0];
            mag1_next[i] = q[i][QUAT_W-1] ? MAG_W'(-q[i]) : q[i];
        end
    end

    // Stage 2: sum of squares.
    logic                       v2_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [3:0][MAG_W-1:0]      mag2_reg;
    logic [3:0]                 neg2_reg;

    // Root digit stages.
    logic [RW-1:0]              sr_v_reg;
    logic [RW-1:0]              sr_root_reg [RW];
    logic [RW+1:0]              sr_rem_reg  [RW];
    logic [2*RW-1:0]            sr_rad_reg  [RW];
    logic [3:0][MAG_W-1:0]      sr_mag_reg  [RW];
    logic [3:0]                 sr_neg_reg  [RW];

    // Division stages.
    logic [QTW-1:0]             dv_v_reg;
    logic [3:0][RW-1:0]         dv_rem_reg  [QTW];
    logic [3:0][QTW-1:0]        dv_quo_reg  [QTW];
    logic [RW-1:0]              dv_root_reg [QTW];
    logic [QTW-1:0]             dv_zero_reg;
    logic [3:0]                 dv_neg_reg  [QTW];

    // Output stage.
    logic                       vo_reg;
    logic [3:0][NW-1:0]         n_reg, n_next;

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Front stages payload.
    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        mag1_reg <= mag1_next;
        for (int i = 0; i < 4; i++)
        begin
            neg1_reg[i] <= q[i][QUAT_W-1];
        end
        sum_reg  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1])
                  + SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);
        mag2_reg <= mag1_reg;
        neg2_reg <= neg1_reg;
    end

    // One root bit per stage from the radicand sum << 2F.
    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        logic                  v_in;
        logic [RW-1:0]         root_in;
        logic [RW+1:0]         rem_in, rem_sh, trial;
        logic [2*RW-1:0]       rad_in;
        logic [3:0][MAG_W-1:0] mag_in;
        logic [3:0]            neg_in;
        logic                  ge;

        if (k == 0)
        begin : g_first
            assign v_in    = v2_reg;
            assign root_in = '0;
            assign rem_in  = '0;
            assign rad_in  = {1'b0, sum_reg, {(2 * F){1'b0}}};
            assign mag_in  = mag2_reg;
            assign neg_in  = neg2_reg;
        end
        else
        begin : g_next
            assign v_in    = sr_v_reg[k-1];
            assign root_in = sr_root_reg[k-1];
            assign rem_in  = sr_rem_reg[k-1];
            assign rad_in  = sr_rad_reg[k-1];
            assign mag_in  = sr_mag_reg[k-1];
            assign neg_in  = sr_neg_reg[k-1];
        end

        assign rem_sh = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sr_v_reg[k] <= 1'b0;
            end
            else
            begin
                sr_v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sr_root_reg[k] <= {root_in[RW-2:0], ge};
            sr_rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
            sr_rad_reg[k]  <= rad_in << 2;
            sr_mag_reg[k]  <= mag_in;
            sr_neg_reg[k]  <= neg_in;
        end
    end

    // One quotient bit per stage of (magnitude << 2F) / root.
    for (genvar j = 0; j < QTW; j++)
    begin : g_div
        logic                  v_in;
        logic [3:0][RW-1:0]    rem_in;
        logic [3:0][QTW-1:0]   quo_in;
        logic [RW-1:0]         root_in;
        logic                  zero_in;
        logic [3:0]            neg_in;
        logic [3:0][RW-1:0]    rem_out;
        logic [3:0][QTW-1:0]   quo_out;

        if (j == 0)
        begin : g_first
            // The upper dividend bits sit below the root; the lower bits are zero.
            assign v_in    = sr_v_reg[RW-1];
            assign root_in = sr_root_reg[RW-1];
            assign zero_in = (sr_root_reg[RW-1] == '0);
            assign neg_in  = sr_neg_reg[RW-1];
            assign quo_in  = '0;
            for (genvar i = 0; i < 4; i++)
            begin : g_init
                assign rem_in[i] = RW'(sr_mag_reg[RW-1][i]) << (F - 3);
            end
        end
        else
        begin : g_next
            assign v_in    = dv_v_reg[j-1];
            assign root_in = dv_root_reg[j-1];
            assign zero_in = dv_zero_reg[j-1];
            assign neg_in  = dv_neg_reg[j-1];
            assign quo_in  = dv_quo_reg[j-1];
            assign rem_in  = dv_rem_reg[j-1];
        end

        always_comb
        begin
            logic [RW:0] rem2;
            logic        ge;
            for (int i = 0; i < 4; i++)
            begin
                rem2       = {rem_in[i], 1'b0};
                ge         = (rem2 >= {1'b0, root_in});
                rem_out[i] = ge ? RW'(rem2 - {1'b0, root_in}) : rem2[RW-1:0];
                quo_out[i] = {quo_in[i][QTW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            else
            begin
                dv_v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[j]  <= rem_out;
            dv_quo_reg[j]  <= quo_out;
            dv_root_reg[j] <= root_in;
            dv_zero_reg[j] <= zero_in;
            dv_neg_reg[j]  <= neg_in;
        end
    end

    // Sign back on; a vanishing root gives the identity rotation.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (dv_zero_reg[QTW-1])
            begin
                n_next[i] = (i == 0) ? NW'(1) << F : '0;
            end
            else if (dv_neg_reg[QTW-1][i])
            begin
                n_next[i] = NW'(-{1'b0, dv_quo_reg[QTW-1][i]});
            end
            else
            begin
                n_next[i] = NW'({1'b0, dv_quo_reg[QTW-1][i]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= dv_v_reg[QTW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
    end

    assign out_valid = vo_reg;
    assign n         = n_reg;

endmodule

// ===== design/hpe_rot.sv =====
// Four-stage exact rotation of one vector: v*2^2F + w*t + qv x t, t = 2*(qv x v).
module hpe_rot #(
    parameter int QUAT_FRAC_BITS = hpe_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    input  logic [3:0][hpe_pkg::nrm_w(QUAT_FRAC_BITS)-1:0]   n,
    input  logic [2:0][hpe_pkg::VEC_W-1:0]                   v,
    output logic                                             out_valid,
    output logic [2:0][hpe_pkg::rot_w(QUAT_FRAC_BITS)-1:0]   r
);
    import hpe_pkg::*;

    localparam int F   = QUAT_FRAC_BITS;
    localparam int NW  = nrm_w(F);
    localparam int PW  = NW + VEC_W;
    localparam int TW  = PW + 2;
    localparam int MW  = NW + TW;
    localparam int OW  = rot_w(F);

    logic [ROT_LAT-1:0]          v_reg;

    // Stage A: products of the first cross product.
    logic signed [PW-1:0]        pa_reg [3], pb_reg [3], pa_next [3], pb_next [3];
    logic [3:0][NW-1:0]          na_reg, nb_reg;
    logic [2:0][VEC_W-1:0]       va_reg, vb_reg, vc_reg;

    // Stage B: t.
    logic signed [TW-1:0]        t_reg [3], t_next [3];

    // Stage C: products of w*t and the second cross product.
    logic signed [MW-1:0]        wt_reg [3], da_reg [3], db_reg [3];
    logic signed [MW-1:0]        wt_next [3], da_next [3], db_next [3];

    // Stage D: exact sum.
    logic signed [OW-1:0]        r_reg [3], r_next [3];

    always_comb
    begin
        pa_next[0] = $signed(n[2]) * $signed(v[2]);
        pb_next[0] = $signed(n[3]) * $signed(v[1]);
        pa_next[1] = $signed(n[3]) * $signed(v[0]);
        pb_next[1] = $signed(n[1]) * $signed(v[2]);
        pa_next[2] = $signed(n[1]) * $signed(v[1]);
        pb_next[2] = $signed(n[2]) * $signed(v[0]);
    end

    always_comb
    begin
        logic signed [TW-1:0] dif;
        for (int i = 0; i < 3; i++)
        begin
            dif       = TW'(pa_reg[i]) - TW'(pb_reg[i]);
            t_next[i] = dif <<< 1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wt_next[i] = $signed(nb_reg[0]) * t_reg[i];
        end
        da_next[0] = $signed(nb_reg[2]) * t_reg[2];
        db_next[0] = $signed(nb_reg[3]) * t_reg[1];
        da_next[1] = $signed(nb_reg[3]) * t_reg[0];
        db_next[1] = $signed(nb_reg[1]) * t_reg[2];
        da_next[2] = $signed(nb_reg[1]) * t_reg[1];
        db_next[2] = $signed(nb_reg[2]) * t_reg[0];
    end

    always_comb
    begin
        logic signed [OW-1:0] vs;
        for (int i = 0; i < 3; i++)
        begin
            vs        = OW'($signed(vc_reg[i])) <<< (2 * F);
            r_next[i] = vs + OW'(wt_reg[i]) + OW'(da_reg[i]) - OW'(db_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[ROT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= pa_next;
        pb_reg <= pb_next;
        na_reg <= n;
        va_reg <= v;
        t_reg  <= t_next;
        nb_reg <= na_reg;
        vb_reg <= va_reg;
        wt_reg <= wt_next;
        da_reg <= da_next;
        db_reg <= db_next;
        vc_reg <= vb_reg;
        r_reg  <= r_next;
    end

    assign out_valid = v_reg[ROT_LAT-1];

    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign r[i] = r_reg[i];
    end

endmodule

// ===== design/hpe_chk.sv =====
// Port-level checker for the head pose eye transform, bound to the top level.
module hpe_chk #(
    parameter int QUAT_FRAC_BITS = hpe_pkg::QUAT_FRAC_BITS_DEF
) (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input hpe_pkg::pose_t   pose,
    input logic             done,
    input hpe_pkg::result_t result
);
    import hpe_pkg::*;

    localparam int LAT = total_lat(QUAT_FRAC_BITS);

    // Every accepted beat comes out after the fixed latency.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted pose produced no result");

    // No result without an accepted beat the fixed latency earlier.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching pose");

    // A zero quaternion does not rotate: both eyes share y and z.
    a_zero_quat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && pose.quat_w == '0 && pose.quat_x == '0
         && pose.quat_y == '0 && pose.quat_z == '0)
        |-> ##LAT (result.left_eye_y == result.right_eye_y
                   && result.left_eye_z == result.right_eye_z))
        else $error("zero quaternion rotated the eyes");

endmodule

bind head_pose_eye_transform_unit hpe_chk #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_hpe_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .pose   (pose),
    .done   (done),
    .result (result)
);
